>>> sv/bmt_pkg.sv
// shared types and constants for the breakpoint match table
`timescale 1ns / 1ps
package bmt_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  // opcodes
  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_ENABLE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_SETHIT  = 3'd4;
  localparam logic [2:0] OP_MKCOND  = 3'd5;
  localparam logic [2:0] OP_CHECK   = 3'd6;
  localparam logic [2:0] OP_CLEAR   = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // kinds
  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_COND = 2'd1;
  localparam logic [1:0] KIND_HIT  = 2'd2;
  localparam logic [1:0] KIND_LOG  = 2'd3;

  // count modes
  localparam logic [1:0] MODE_EQ  = 2'd0;
  localparam logic [1:0] MODE_GE  = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;

  // one slot's record as held in the entry memory
  typedef struct packed {
    logic [15:0] id;
    logic [31:0] offset;
    logic [1:0]  kind;
    logic        enabled;
    logic [30:0] target;
    logic [1:0]  mode;
    logic [31:0] hits;
  } slot_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic zero_rem;
  } div_rsp_t;

endpackage

>>> sv/breakpoint_match_table.sv
// top level of the breakpoint match table
//
//  channel  ports                         handshake
//  request  in_* fields                   start high, busy low
//  result   out_* fields                  out_valid strobe, one cycle
//
// add writes its slot in an exec step and then strobes; clear-all goes straight to
// the done step. remove, enable, disable, set, make-conditional and check sweep the slot
// memory one entry a cycle until a match, then run the exec step; a
// multiple-mode check also waits for the remainder unit
// synchronous reset empties the table (valid bits) and restarts ids at 1.
// the receiver cannot stall; busy stays high until the result strobe.
`timescale 1ns / 1ps
module breakpoint_match_table
  import bmt_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_entry_ref,
  input  logic [31:0] in_code_offset,
  input  logic [1:0]  in_bp_kind,
  input  logic [30:0] in_target_hits,
  input  logic [1:0]  in_count_mode,
  input  logic        in_condition_met,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_ref,
  output logic        out_matched,
  output logic        out_break_now,
  output logic        out_is_log,
  output logic [31:0] out_hits_now
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_DIV   = 6'b001000,
    S_WB    = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // slot memory, registered read
  slot_t mem [MAX_ENTRIES];
  slot_t rd_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  slot_t         wr_data;

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [15:0]   idc_r, idc_nxt;

  // latched request
  logic [2:0]  op_r;
  logic [15:0] ref_r;
  logic [31:0] offs_r;
  logic [1:0]  kind_r, mode_r;
  logic [30:0] tgt_r;
  logic        cond_r;

  logic [CW-1:0] idx_r, idx_nxt;
  logic          rdv_r, rdv_nxt;      // rd_r holds slot at pidx_r
  logic [IW-1:0] pidx_r, pidx_nxt;
  slot_t         hit_r, hit_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  st_r, st_nxt;
  logic [15:0] rr_r, rr_nxt;
  logic        m_r, m_nxt, b_r, b_nxt, l_r, l_nxt;
  logic [31:0] h_r, h_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [IW-1:0] free_idx;
  logic          free_ok;
  logic          hit_found;
  logic [31:0]   newhits;

  bmt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  // first free slot, priority over the valid bits
  always_comb begin
    free_idx = '0;
    free_ok  = 1'b0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IW'(i);
        free_ok  = 1'b1;
      end
    end
  end

  assign hit_found = (op_r == OP_CHECK) ?
                     (rd_r.enabled && rd_r.offset == offs_r) :
                     (rd_r.id == ref_r);
  assign newhits = (hit_r.hits == 32'hFFFF_FFFF) ? hit_r.hits : hit_r.hits + 32'd1;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    live_nxt  = live_r;
    idc_nxt   = idc_r;
    idx_nxt   = idx_r;
    rdv_nxt   = 1'b0;
    pidx_nxt  = idx_r[IW-1:0];
    hit_nxt   = hit_r;
    hidx_nxt  = hidx_r;
    rd_addr   = idx_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = hidx_r;
    wr_data   = hit_r;
    ov_nxt    = 1'b0;
    st_nxt    = st_r;
    rr_nxt    = rr_r;
    m_nxt     = m_r;
    b_nxt     = b_r;
    l_nxt     = l_r;
    h_nxt     = h_r;
    dreq.start    = 1'b0;
    dreq.dividend = newhits;
    dreq.divisor  = hit_r.target;
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (start) begin
          st_nxt = ST_OK; rr_nxt = '0; m_nxt = 1'b0; b_nxt = 1'b0;
          l_nxt = 1'b0; h_nxt = '0;
          unique case (in_opcode)
            OP_CLEAR: state_nxt = S_DONE;
            OP_ADD:   state_nxt = S_EXEC;
            default:  state_nxt = S_SCAN;
          endcase
        end
      end
      // sweep entries; a read issued this cycle is checked next cycle
      S_SCAN: begin
        if (rdv_r && valid_r[pidx_r] && hit_found &&
            !(op_r != OP_CHECK && ref_r == 16'd0)) begin
          hit_nxt   = rd_r;
          hidx_nxt  = pidx_r;
          state_nxt = S_EXEC;
        end else if (idx_r == CW'(MAX_ENTRIES)) begin
          if (!rdv_r) begin
            st_nxt    = (op_r == OP_CHECK) ? ST_OK : ST_NOTFOUND;
            state_nxt = S_DONE;
          end
        end else begin
          rdv_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_ADD: begin
            if (live_r < CW'(MAX_ENTRIES) && idc_r != 16'd0 && free_ok) begin
              wr_en   = 1'b1;
              wr_addr = free_idx;
              wr_data.id      = idc_r;
              wr_data.offset  = offs_r;
              wr_data.kind    = kind_r;
              wr_data.enabled = 1'b1;
              wr_data.target  = (kind_r == KIND_HIT) ? tgt_r : '0;
              wr_data.mode    = (kind_r == KIND_HIT) ? mode_r : '0;
              wr_data.hits    = '0;
              valid_nxt[free_idx] = 1'b1;
              live_nxt = live_r + CW'(1);
              rr_nxt   = idc_r;
              idc_nxt  = idc_r + 16'd1;
            end else begin
              st_nxt = ST_FULL;
            end
            state_nxt = S_DONE;
          end
          OP_REMOVE: begin
            valid_nxt[hidx_r] = 1'b0;
            live_nxt  = live_r - CW'(1);
            state_nxt = S_DONE;
          end
          OP_ENABLE, OP_DISABLE: begin
            wr_en = 1'b1;
            wr_data.enabled = (op_r == OP_ENABLE);
            state_nxt = S_DONE;
          end
          OP_SETHIT: begin
            wr_en = 1'b1;
            wr_data.kind   = KIND_HIT;
            wr_data.target = tgt_r;
            wr_data.mode   = mode_r;
            state_nxt = S_DONE;
          end
          OP_MKCOND: begin
            wr_en = 1'b1;
            wr_data.kind = KIND_COND;
            state_nxt = S_DONE;
          end
          default: begin
            // check: count the hit and decide
            wr_en = 1'b1;
            wr_data.hits = newhits;
            hit_nxt.hits = newhits;
            m_nxt  = 1'b1;
            rr_nxt = hit_r.id;
            h_nxt  = newhits;
            l_nxt  = (hit_r.kind == KIND_LOG);
            state_nxt = S_DONE;
            case (hit_r.kind)
              KIND_LINE: b_nxt = 1'b1;
              KIND_COND: b_nxt = cond_r;
              KIND_HIT: begin
                case (hit_r.mode)
                  MODE_EQ: b_nxt = (newhits == {1'b0, hit_r.target});
                  MODE_GE: b_nxt = (newhits >= {1'b0, hit_r.target});
                  MODE_MUL: begin
                    if (hit_r.target != 31'd0) begin
                      dreq.start = 1'b1;
                      state_nxt  = S_DIV;
                    end
                  end
                  default: b_nxt = 1'b0;
                endcase
              end
              default: b_nxt = 1'b0;
            endcase
          end
        endcase
      end
      S_DIV: begin
        if (drsp.done) begin
          b_nxt     = drsp.zero_rem;
          state_nxt = S_DONE;
        end
      end
      S_WB: state_nxt = S_DONE;
      S_DONE: begin
        if (op_r == OP_CLEAR) begin
          valid_nxt = '0;
          live_nxt  = '0;
        end
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      live_r  <= '0;
      idc_r   <= 16'd1;
      ov_r    <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
      idc_r   <= idc_nxt;
      ov_r    <= ov_nxt;
      rdv_r   <= rdv_nxt;
    end
    if (state_r == S_IDLE && start) begin
      op_r <= in_opcode; ref_r <= in_entry_ref; offs_r <= in_code_offset;
      kind_r <= in_bp_kind; tgt_r <= in_target_hits; mode_r <= in_count_mode;
      cond_r <= in_condition_met;
    end
    idx_r  <= idx_nxt;
    pidx_r <= pidx_nxt;
    hit_r  <= hit_nxt;
    hidx_r <= hidx_nxt;
    st_r <= st_nxt; rr_r <= rr_nxt; m_r <= m_nxt;
    b_r <= b_nxt; l_r <= l_nxt; h_r <= h_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = st_r;
  assign out_result_ref = rr_r;
  assign out_matched    = m_r;
  assign out_break_now  = b_r;
  assign out_is_log     = l_r;
  assign out_hits_now   = h_r;

endmodule

>>> sv/bmt_div.sv
// bit-serial remainder unit: tells whether dividend mod divisor is zero
`timescale 1ns / 1ps
module bmt_div
  import bmt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  // one restoring step per cycle
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {2'b0, dvs_r};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'd32;
      run_nxt = 1'b1;
    end else if (run_r) begin
      quo_nxt = {quo_r[30:0], 1'b0};
      if (!trial[32]) rem_nxt = trial[31:0];
      else            rem_nxt = {rem_r[30:0], quo_r[31]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.zero_rem = (rem_r == 32'd0);

endmodule

>>> tb/breakpoint_match_table_test.sv
// self-checking testbench for the breakpoint match table
`timescale 1ns / 1ps
module breakpoint_match_table_test;
  import bmt_pkg::*;

  localparam int SLOTS = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] entry_ref;
    logic [31:0] code_offset;
    logic [1:0]  bp_kind;
    logic [30:0] target_hits;
    logic [1:0]  count_mode;
    logic        condition_met;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_ref;
    logic        matched;
    logic        break_now;
    logic        is_log;
    logic [31:0] hits_now;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  in_opcode = '0;
  logic [15:0] in_entry_ref = '0;
  logic [31:0] in_code_offset = '0;
  logic [1:0]  in_bp_kind = '0;
  logic [30:0] in_target_hits = '0;
  logic [1:0]  in_count_mode = '0;
  logic        in_condition_met = 1'b0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_result_ref;
  logic        out_matched;
  logic        out_break_now;
  logic        out_is_log;
  logic [31:0] out_hits_now;

  breakpoint_match_table u_dut (.*);

  always #6 clk = ~clk;

  // shadow copy of the table
  logic        tbl_valid [SLOTS];
  logic [15:0] tbl_id [SLOTS];
  logic [31:0] tbl_offset [SLOTS];
  logic [1:0]  tbl_kind [SLOTS];
  logic        tbl_enabled [SLOTS];
  logic [30:0] tbl_target [SLOTS];
  logic [1:0]  tbl_mode [SLOTS];
  logic [31:0] tbl_hits [SLOTS];
  int          tbl_live;
  logic [15:0] next_id;

  answer_t pending_answers[$];
  int error_count = 0;
  int sent_count = 0;
  int break_count = 0;
  int cycle_count = 0;

  // table model: applies one request and returns its answer
  function automatic answer_t apply_request(request_t r);
    answer_t a;
    int s;
    logic [31:0] h;
    logic [31:0] t;
    a = '0;
    s = -1;
    case (r.opcode)
      OP_ADD: begin
        if (tbl_live < SLOTS && next_id != 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (!tbl_valid[i] && s < 0) s = i;
        end
        if (s < 0) a.status = ST_FULL;
        else begin
          tbl_valid[s] = 1'b1;
          tbl_id[s] = next_id;
          tbl_offset[s] = r.code_offset;
          tbl_kind[s] = r.bp_kind;
          tbl_enabled[s] = 1'b1;
          tbl_target[s] = (r.bp_kind == KIND_HIT) ? r.target_hits : '0;
          tbl_mode[s] = (r.bp_kind == KIND_HIT) ? r.count_mode : '0;
          tbl_hits[s] = '0;
          tbl_live++;
          a.result_ref = next_id;
          next_id = next_id + 16'd1;
        end
      end
      OP_CHECK: begin
        for (int i = 0; i < SLOTS; i++)
          if (s < 0 && tbl_valid[i] && tbl_enabled[i] && tbl_offset[i] == r.code_offset)
            s = i;
        if (s >= 0) begin
          if (tbl_hits[s] != 32'hFFFF_FFFF) tbl_hits[s]++;
          h = tbl_hits[s];
          t = {1'b0, tbl_target[s]};
          a.matched = 1'b1;
          a.result_ref = tbl_id[s];
          a.hits_now = h;
          a.is_log = (tbl_kind[s] == KIND_LOG);
          case (tbl_kind[s])
            KIND_LINE: a.break_now = 1'b1;
            KIND_COND: a.break_now = r.condition_met;
            KIND_HIT: begin
              case (tbl_mode[s])
                MODE_EQ:  a.break_now = (h == t);
                MODE_GE:  a.break_now = (h >= t);
                MODE_MUL: a.break_now = (t != 0) && (h % t == 0);
                default:  a.break_now = 1'b0;
              endcase
            end
            default: a.break_now = 1'b0;
          endcase
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_live = 0;
      end
      default: begin
        if (r.entry_ref != 0)
          for (int i = 0; i < SLOTS; i++)
            if (s < 0 && tbl_valid[i] && tbl_id[i] == r.entry_ref) s = i;
        if (s < 0) a.status = ST_NOTFOUND;
        else begin
          case (r.opcode)
            OP_REMOVE: begin
              tbl_valid[s] = 1'b0;
              tbl_live--;
            end
            OP_ENABLE:  tbl_enabled[s] = 1'b1;
            OP_DISABLE: tbl_enabled[s] = 1'b0;
            OP_SETHIT: begin
              tbl_kind[s] = KIND_HIT;
              tbl_target[s] = r.target_hits;
              tbl_mode[s] = r.count_mode;
            end
            default: tbl_kind[s] = KIND_COND;
          endcase
        end
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
  endtask

  // send one request after a random gap, then wait for acceptance
  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    while (busy) @(negedge clk);
    in_opcode = r.opcode;
    in_entry_ref = r.entry_ref;
    in_code_offset = r.code_offset;
    in_bp_kind = r.bp_kind;
    in_target_hits = r.target_hits;
    in_count_mode = r.count_mode;
    in_condition_met = r.condition_met;
    start = 1'b1;
    @(posedge clk);
    pending_answers.push_back(apply_request(r));
    sent_count++;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic request_t noise_request();
    request_t r;
    r = '0;
    r.opcode = $urandom;
    r.entry_ref = $urandom;
    r.code_offset = $urandom;
    r.bp_kind = $urandom;
    r.target_hits = $urandom;
    r.count_mode = $urandom;
    r.condition_met = $urandom;
    return r;
  endfunction

  function automatic logic [15:0] some_live_id();
    int s;
    s = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[(s + i) % SLOTS]) return tbl_id[(s + i) % SLOTS];
    return 16'd0;
  endfunction

  task automatic send_op(logic [2:0] op, logic [15:0] id, logic [31:0] offs,
                         logic [1:0] kind, logic [30:0] target, logic [1:0] mode,
                         logic cond);
    request_t r;
    r = '{op, id, offs, kind, target, mode, cond};
    send_request(r);
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("unexpected result at cycle %0d", cycle_count);
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_result_ref !== want.result_ref)
          report_mismatch("result_ref", out_result_ref, want.result_ref);
        if (out_matched !== want.matched) report_mismatch("matched", out_matched, want.matched);
        if (out_break_now !== want.break_now)
          report_mismatch("break_now", out_break_now, want.break_now);
        if (out_is_log !== want.is_log) report_mismatch("is_log", out_is_log, want.is_log);
        if (out_hits_now !== want.hits_now)
          report_mismatch("hits_now", out_hits_now, want.hits_now);
        if (want.break_now) break_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // extremes, every opcode, zero and unknown ids, all kinds and modes
  task automatic test_directed();
    send_op(OP_CHECK, 16'd0, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_REMOVE, 16'd0, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_ENABLE, 16'hFFFF, '1, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_ADD, 16'd0, 32'hFFFF_FFFF, KIND_LINE, '1, MODE_MUL, 1'b0);
    send_op(OP_ADD, 16'd0, 32'd0, KIND_COND, '0, MODE_EQ, 1'b0);
    send_op(OP_ADD, 16'd0, 32'd4, KIND_HIT, 31'd2, MODE_MUL, 1'b0);
    send_op(OP_ADD, 16'd0, 32'd8, KIND_LOG, 31'd5, MODE_GE, 1'b1);
    send_op(OP_ADD, 16'd0, 32'd12, KIND_HIT, 31'd0, MODE_MUL, 1'b0);
    send_op(OP_ADD, 16'd0, 32'd16, KIND_HIT, 31'd1, 2'd3, 1'b0);
    send_op(OP_ADD, 16'd0, 32'd20, KIND_HIT, '1, MODE_GE, 1'b0);
    send_op(OP_CHECK, 16'd0, 32'hFFFF_FFFF, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_CHECK, 16'd0, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b1);
    send_op(OP_CHECK, 16'd0, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
    for (int i = 0; i < 3; i++) send_op(OP_CHECK, 16'd0, 32'd4, 0, '0, 0, 1'b0);
    send_op(OP_CHECK, 16'd0, 32'd8, KIND_LINE, '0, MODE_EQ, 1'b1);
    send_op(OP_CHECK, 16'd0, 32'd12, KIND_LINE, '0, MODE_EQ, 1'b1);
    send_op(OP_CHECK, 16'd0, 32'd16, KIND_LINE, '0, MODE_EQ, 1'b1);
    send_op(OP_DISABLE, 16'd1, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_CHECK, 16'd0, 32'hFFFF_FFFF, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_SETHIT, 16'd2, 32'd0, KIND_LINE, 31'd1, MODE_EQ, 1'b0);
    send_op(OP_MKCOND, 16'd3, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
    send_op(OP_CHECK, 16'd0, 32'd4, KIND_LINE, '0, MODE_EQ, 1'b1);
    send_op(OP_CLEAR, 16'd0, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
  endtask

  // fill past capacity to hit the table-full refusal
  task automatic test_table_full();
    for (int i = 0; i < SLOTS + 2; i++)
      send_op(OP_ADD, 16'd0, $urandom_range(0, 7), $urandom, $urandom_range(0, 3),
              $urandom_range(0, 3), 1'b0);
    wait_drained();
    send_op(OP_CLEAR, 16'd0, 32'd0, KIND_LINE, '0, MODE_EQ, 1'b0);
  endtask

  // mostly well-formed traffic on a small offset pool
  task automatic test_random_traffic(int count);
    request_t r;
    for (int n = 0; n < count; n++) begin
      r = noise_request();
      if ($urandom_range(0, 9) != 0) begin
        r.code_offset = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 11);
        r.target_hits = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 6);
        r.count_mode = $urandom_range(0, 3);
        case ($urandom_range(0, 19))
          0, 1, 2, 3:  r.opcode = OP_ADD;
          4, 5:        r.opcode = OP_REMOVE;
          6:           r.opcode = OP_ENABLE;
          7:           r.opcode = OP_DISABLE;
          8:           r.opcode = OP_SETHIT;
          9:           r.opcode = OP_MKCOND;
          19:          r.opcode = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_CHECK;
          default:     r.opcode = OP_CHECK;
        endcase
        if ($urandom_range(0, 7) != 0) r.entry_ref = some_live_id();
      end
      send_request(r);
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_offset[i] = '0;
      tbl_kind[i] = '0;
      tbl_enabled[i] = 1'b0;
      tbl_target[i] = '0;
      tbl_mode[i] = '0;
      tbl_hits[i] = '0;
    end
    tbl_live = 0;
    next_id = 16'd1;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_random_traffic(1200);
    wait_drained();
    repeat (80) @(negedge clk);
    $display("sent %0d requests over every opcode, kind and count mode", sent_count);
    $display("%0d checks broke, table-full refusals exercised", break_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
